@@ design/sqt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqt_pkg
// shared types, codes and constants of the shell quote tokenizer
// ----------------------------------------------------------------------------
package sqt_pkg;

	// word count and word index width, fixed by the result fields
	localparam int IDX_W = 6;

	// word slots; the usable word limit is MAX_WORDS-1
	localparam int MAX_WORDS = 64;

	// default word length bound; a word holds at most MAX_WORD_LEN-1 bytes
	localparam int MAX_WORD_LEN_DEF = 256;

	// reset value of the word limit register
	localparam logic [IDX_W-1:0] MAX_TOKENS_RST = 6'd63;

	// depth of the queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// input commands
	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_EOL  = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_EOW  = 2'd1;
	localparam logic [1:0] KIND_EOL  = 2'd2;

	// characters with a meaning to the splitter
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_in;
	} in_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       char_out;
		logic [IDX_W-1:0] word_index;
		logic             truncated;
		logic             last_result;
	} out_t;

	// up to three results caused by one input, r[0] first
	typedef struct packed {
		logic [1:0]      n;
		out_t [2:0]      r;
	} bundle_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

@@ design/sqt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqt_front
// classifies each input byte, updates the quote state, builds result bundles
// ----------------------------------------------------------------------------
module sqt_front
	import sqt_pkg::*;
#(
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  in_t              item,
	input  logic             max_tokens_we,
	input  logic [IDX_W-1:0] max_tokens_wdata,
	output logic             q_push,
	output bundle_t          bundle
);

	localparam int LEN_W = (MAX_WORD_LEN > 2) ? $clog2(MAX_WORD_LEN) : 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD_LEN - 1);
	localparam logic [IDX_W-1:0] WORDS_MAX = IDX_W'(MAX_WORDS - 1);

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_SINGLE = 2'd1,
		MODE_DOUBLE = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]       n;
		out_t [2:0]       r;
		logic [LEN_W-1:0] len;
		logic             ovf;
		logic [IDX_W-1:0] cnt;
	} acc_t;

	mode_t            mode_q, mode_d;
	logic             esc_q, esc_d;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] max_tokens_q;
	logic [IDX_W-1:0] lim;
	logic             room;
	acc_t             acc;

	function automatic acc_t add_chr(input acc_t a, input logic [7:0] c);
		acc_t b;
		b = a;
		if (a.len < LEN_MAX) begin
			b.r[a.n] = '{kind: KIND_CHAR, char_out: c, word_index: a.cnt,
				truncated: a.ovf, last_result: 1'b0};
			b.n = a.n + 2'd1;
			b.len = a.len + LEN_W'(1);
		end else begin
			b.ovf = 1'b1;
		end
		return b;
	endfunction

	function automatic acc_t end_wrd(input acc_t a);
		acc_t b;
		b = a;
		if (a.len != '0) begin
			b.r[a.n] = '{kind: KIND_EOW, char_out: 8'd0, word_index: a.cnt,
				truncated: a.ovf, last_result: 1'b0};
			b.n = a.n + 2'd1;
			b.cnt = a.cnt + IDX_W'(1);
			b.len = '0;
			b.ovf = 1'b0;
		end
		return b;
	endfunction

	assign lim  = (max_tokens_q > WORDS_MAX) ? WORDS_MAX : max_tokens_q;
	assign room = cnt_q < lim;

	always_comb begin
		acc = '{n: 2'd0, r: '0, len: len_q, ovf: ovf_q, cnt: cnt_q};
		mode_d = mode_q;
		esc_d = esc_q;
		if (item.cmd == CMD_EOL) begin
			if (room) begin
				if (esc_q) begin
					acc = add_chr(acc, CH_BSLASH);
				end
				acc = end_wrd(acc);
			end
			acc.r[acc.n] = '{kind: KIND_EOL, char_out: 8'd0, word_index: acc.cnt,
				truncated: 1'b0, last_result: 1'b0};
			acc.n = acc.n + 2'd1;
			acc.len = '0;
			acc.ovf = 1'b0;
			acc.cnt = '0;
			mode_d = MODE_NORMAL;
			esc_d = 1'b0;
		end else if (room) begin
			case (mode_q)
				MODE_SINGLE: begin
					if (item.char_in == CH_SQUOTE) begin
						mode_d = MODE_NORMAL;
					end else begin
						acc = add_chr(acc, item.char_in);
					end
				end
				MODE_DOUBLE: begin
					if (esc_q) begin
						esc_d = 1'b0;
						if (item.char_in inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR}) begin
							acc = add_chr(acc, item.char_in);
						end else begin
							acc = add_chr(acc, CH_BSLASH);
							acc = add_chr(acc, item.char_in);
						end
					end else if (item.char_in == CH_DQUOTE) begin
						mode_d = MODE_NORMAL;
					end else if (item.char_in == CH_BSLASH) begin
						esc_d = 1'b1;
					end else begin
						acc = add_chr(acc, item.char_in);
					end
				end
				default: begin
					if (item.char_in == CH_SQUOTE) begin
						mode_d = MODE_SINGLE;
					end else if (item.char_in == CH_DQUOTE) begin
						mode_d = MODE_DOUBLE;
					end else if (item.char_in inside {CH_SPACE, CH_TAB, CH_NL}) begin
						acc = end_wrd(acc);
					end else begin
						acc = add_chr(acc, item.char_in);
					end
				end
			endcase
		end
		if (acc.n != 2'd0) begin
			acc.r[acc.n - 2'd1].last_result = 1'b1;
		end
	end

	assign bundle.n = acc.n;
	assign bundle.r = acc.r;
	assign q_push   = accept && (acc.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NORMAL;
			esc_q        <= 1'b0;
			len_q        <= '0;
			ovf_q        <= 1'b0;
			cnt_q        <= '0;
			max_tokens_q <= MAX_TOKENS_RST;
		end else begin
			if (accept) begin
				mode_q <= mode_d;
				esc_q  <= esc_d;
				len_q  <= acc.len;
				ovf_q  <= acc.ovf;
				cnt_q  <= acc.cnt;
			end
			if (max_tokens_we) begin
				max_tokens_q <= max_tokens_wdata;
			end
		end
	end

	// every accepted input that causes results hands over a non-empty bundle
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> bundle.r[bundle.n - 2'd1].last_result)
		else $error("pushed bundle without last result");

	// end of line returns the quote state and counters to their reset values
	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.cmd == CMD_EOL) |=>
		(cnt_q == '0 && len_q == '0 && !esc_q && mode_q == MODE_NORMAL))
		else $error("state not cleared after end of line");

	// a pending backslash only exists inside double quotes
	a_esc_in_dq: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> mode_q == MODE_DOUBLE)
		else $error("escape pending outside double quotes");

endmodule

@@ design/sqt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqt_queue
// short register queue of result bundles between front and back
// ----------------------------------------------------------------------------
module sqt_queue
	import sqt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  bundle_t wr_data,
	input  logic    rd_en,
	output bundle_t rd_data,
	output q_stat_t stat
);

	bundle_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/sqt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqt_back
// walks the head bundle one result per transfer and retires it
// ----------------------------------------------------------------------------
module sqt_back
	import sqt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  bundle_t head,
	input  q_stat_t q_stat,
	input  logic    pop,
	output logic    empty,
	output out_t    result,
	output logic    q_pop
);

	logic [1:0] sub_q;
	logic       take;
	logic       at_end;

	assign empty  = q_stat.empty;
	assign result = head.r[sub_q];
	assign take   = pop && !q_stat.empty;
	assign at_end = (sub_q == head.n - 2'd1);
	assign q_pop  = take && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 2'd0;
		end else if (take) begin
			sub_q <= at_end ? 2'd0 : sub_q + 2'd1;
		end
	end

endmodule

@@ design/shell_quote_tokenizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_quote_tokenizer_core
// shell style word splitter with single quotes, double quotes and escapes
// ----------------------------------------------------------------------------
// usage
//  - input side is a queue: drive item and push; a transfer happens at an
//    edge with push high and full low. item.cmd selects a byte of the line
//    or end of line
//  - result side is a queue: result is valid while empty is low; a transfer
//    happens at an edge with pop high and empty low
//  - max_tokens_we / max_tokens_wdata write the word limit, only while idle
//  - results of an input are written to the queue at its transfer and are
//    handed out in order from its head. throughput: one input per cycle
//    while full is low; each input gives zero to three results, delivered
//    one per cycle while pop is high from the head of a four entry queue,
//    so the sustained input rate is one per cycle as long as inputs average at most one result each
//  - when the receiver stalls the queue fills and full rises; inputs are
//    held off until a bundle retires
//  - reset clears the quote state, counters and queue, word limit to 63
// ----------------------------------------------------------------------------
module shell_quote_tokenizer_core
	import sqt_pkg::*;
#(
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  in_t              item,
	output logic             empty,
	input  logic             pop,
	output out_t             result,
	input  logic             max_tokens_we,
	input  logic [IDX_W-1:0] max_tokens_wdata
);

	// front to queue
	logic    accept;
	logic    q_push;
	bundle_t bundle;

	// queue to back
	bundle_t head;
	q_stat_t q_stat;
	logic    q_pop;

	// input transfer; an input that gives no result still moves the state
	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	// front: quote state machine and result bundle builder
	sqt_front #(
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.item            (item),
		.max_tokens_we   (max_tokens_we),
		.max_tokens_wdata(max_tokens_wdata),
		.q_push          (q_push),
		.bundle          (bundle)
	);

	// decoupling queue, one entry per input that caused results
	sqt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(bundle),
		.rd_en  (q_pop),
		.rd_data(head),
		.stat   (q_stat)
	);

	// back: hands out results of the head bundle in order
	sqt_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.q_stat(q_stat),
		.pop   (pop),
		.empty (empty),
		.result(result),
		.q_pop (q_pop)
	);

endmodule

@@ tb/tb_shell_quote_tokenizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_quote_tokenizer_core
// self-checking bench for the shell style word splitter
// ----------------------------------------------------------------------------
// bytes of command lines are pushed into the core one transfer at a time and
// a bit-accurate tokenizer model in the bench predicts the word characters,
// word ends and line ends each transfer causes. a checker pops results and
// compares them in order against the predictions. tests cover quoting and
// escapes, the word length bound, the word count limit (also lowered in the
// middle of a line), a long output stall, and random lines under several
// limit settings with random idle bursts on both sides
// ----------------------------------------------------------------------------
module tb_shell_quote_tokenizer_core;
	import sqt_pkg::*;

	localparam int WORD_LEN_MAX = MAX_WORD_LEN_DEF;

	// quote state of the tokenizer model
	typedef enum logic [1:0] {
		QM_NORMAL = 2'd0,
		QM_SINGLE = 2'd1,
		QM_DOUBLE = 2'd2
	} quote_mode_e;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             push;
	logic             full;
	in_t              item;
	logic             empty;
	logic             pop;
	out_t             result;
	logic             max_tokens_we;
	logic [IDX_W-1:0] max_tokens_wdata;

	always #2 clk = ~clk;

	shell_quote_tokenizer_core #(
		.MAX_WORD_LEN(WORD_LEN_MAX)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.item             (item),
		.empty            (empty),
		.pop              (pop),
		.result           (result),
		.max_tokens_we    (max_tokens_we),
		.max_tokens_wdata (max_tokens_wdata)
	);

	// ------------------------------------------------------------------------
	// tokenizer model: own copy of the quote state, counters and word limit
	// ------------------------------------------------------------------------
	quote_mode_e      q_mode    = QM_NORMAL;
	bit               esc_pend  = 1'b0;
	int               wlen      = 0;
	logic [IDX_W-1:0] wcount    = '0;
	bit               wovf      = 1'b0;
	logic [IDX_W-1:0] limit_reg = MAX_TOKENS_RST;

	out_t step_res[$];        // results of the transfer being modeled
	out_t expected_tokens[$]; // predicted results not yet popped

	int  mismatches   = 0;
	int  sent_items   = 0;    // input transfers so far
	bit  tx_idle_en   = 1'b1;
	bit  rx_idle_en   = 1'b1;
	int  long_hold_req = 0;   // receiver stall request, in cycles

	function automatic void emit(logic [1:0] k, logic [7:0] c, logic [IDX_W-1:0] idx,
			logic tr);
		out_t r;
		r.kind        = k;
		r.char_out    = c;
		r.word_index  = idx;
		r.truncated   = tr;
		r.last_result = 1'b0;
		step_res.push_back(r);
	endfunction

	// a word keeps at most WORD_LEN_MAX-1 bytes, the rest only mark overflow
	function automatic void take_char(logic [7:0] c);
		if (wlen < WORD_LEN_MAX - 1) begin
			emit(KIND_CHAR, c, wcount, wovf);
			wlen++;
		end else begin
			wovf = 1'b1;
		end
	endfunction

	// empty words (including empty quotes) produce nothing
	function automatic void close_word();
		if (wlen > 0) begin
			emit(KIND_EOW, 8'h00, wcount, wovf);
			wcount = wcount + IDX_W'(1);
			wlen   = 0;
			wovf   = 1'b0;
		end
	endfunction

	// models one input transfer
	function automatic void tokenize_step(in_t it);
		int         lim;
		bit         room;
		logic [7:0] c;
		out_t       tail;
		lim  = (int'(limit_reg) > MAX_WORDS - 1) ? MAX_WORDS - 1 : int'(limit_reg);
		room = int'(wcount) < lim;
		c    = it.char_in;
		step_res.delete();
		if (it.cmd == CMD_EOL) begin
			// at the word limit a pending backslash and a partial word are lost
			if (room) begin
				if (esc_pend)
					take_char(CH_BSLASH);
				close_word();
			end
			emit(KIND_EOL, 8'h00, wcount, 1'b0);
			q_mode   = QM_NORMAL;
			esc_pend = 1'b0;
			wlen     = 0;
			wcount   = '0;
			wovf     = 1'b0;
		end else if (room) begin
			case (q_mode)
				QM_SINGLE: begin
					if (c == CH_SQUOTE)
						q_mode = QM_NORMAL;
					else
						take_char(c);
				end
				QM_DOUBLE: begin
					if (esc_pend) begin
						// only \" \\ \$ drop the backslash
						esc_pend = 1'b0;
						if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR) begin
							take_char(c);
						end else begin
							take_char(CH_BSLASH);
							take_char(c);
						end
					end else if (c == CH_DQUOTE) begin
						q_mode = QM_NORMAL;
					end else if (c == CH_BSLASH) begin
						esc_pend = 1'b1;
					end else begin
						take_char(c);
					end
				end
				default: begin
					if (c == CH_SQUOTE)
						q_mode = QM_SINGLE;
					else if (c == CH_DQUOTE)
						q_mode = QM_DOUBLE;
					else if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
						close_word();
					else
						take_char(c);
				end
			endcase
		end
		if (step_res.size() > 0) begin
			tail = step_res[step_res.size() - 1];
			tail.last_result = 1'b1;
			step_res[step_res.size() - 1] = tail;
		end
		foreach (step_res[i])
			expected_tokens.push_back(step_res[i]);
	endfunction

	// ------------------------------------------------------------------------
	// input side: one transfer per call, optional random idle burst first
	// ------------------------------------------------------------------------
	task automatic send_item(in_t it);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item <= it;
		push <= 1'b1;
		// full is sampled before the edge, so a low full means the transfer took
		do @(posedge clk); while (full);
		tokenize_step(it);
		sent_items++;
	endtask

	task automatic send_char(logic [7:0] c);
		send_item(in_t'{cmd: CMD_CHAR, char_in: c});
	endtask

	// the byte field is don't-care on end of line, so fill it with noise
	task automatic send_eol();
		send_item(in_t'{cmd: CMD_EOL, char_in: 8'($urandom_range(0, 255))});
	endtask

	// stop pushing and let every predicted result drain out of the core
	task automatic wait_drained();
		push <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		// a transfer with no result may still be in flight
		repeat (4) @(posedge clk);
	endtask

	// word limit register, only touched while the core is idle
	task automatic write_limit(logic [IDX_W-1:0] v);
		wait_drained();
		max_tokens_we    <= 1'b1;
		max_tokens_wdata <= v;
		@(posedge clk);
		max_tokens_we    <= 1'b0;
		limit_reg = v;
	endtask

	// ------------------------------------------------------------------------
	// output side: pop with random stall bursts, plus long stalls on request
	// ------------------------------------------------------------------------
	initial begin : result_receiver
		int hold;
		hold = 0;
		pop  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_req > 0) begin
				hold = long_hold_req;
				long_hold_req = 0;
			end else if (hold == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 13);
			end
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// every popped result must match the oldest prediction
	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n === 1'b1 && pop && !empty) begin
			if (expected_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected result: kind=%0d char=%02h idx=%0d trunc=%0b last=%0b",
						$realtime, result.kind, result.char_out, result.word_index,
						result.truncated, result.last_result);
			end else begin
				want = expected_tokens.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t result mismatch: expected kind=%0d char=%02h idx=%0d trunc=%0b last=%0b",
							$realtime, want.kind, want.char_out, want.word_index,
							want.truncated, want.last_result);
						$display("%0t   got kind=%0d char=%02h idx=%0d trunc=%0b last=%0b",
							$realtime, result.kind, result.char_out,
							result.word_index, result.truncated, result.last_result);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// one line through every quoting rule, then an empty line
	task automatic test_directed_quoting();
		// word "a\0\xff", tab, "\"\$\\\x" in double quotes, space, empty '',
		// newline, ' ' in single quotes, then an open double quote with a
		// backslash still pending when the line ends
		logic [7:0] line_bytes [23] = '{
			8'h61, 8'h00, 8'hff, CH_TAB,
			CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_BSLASH, CH_DOLLAR,
			CH_BSLASH, CH_BSLASH, CH_BSLASH, 8'h78, CH_DQUOTE, CH_SPACE,
			CH_SQUOTE, CH_SQUOTE, CH_NL,
			CH_SQUOTE, CH_SPACE, CH_SQUOTE,
			CH_DQUOTE, CH_BSLASH
		};
		foreach (line_bytes[i])
			send_char(line_bytes[i]);
		send_eol();
		send_eol();
	endtask

	// a word past the length bound drops bytes and flags truncation
	task automatic test_word_overflow();
		repeat (WORD_LEN_MAX)
			send_char(8'h61 + 8'($urandom_range(0, 25)));
		send_char(CH_SPACE);
		send_eol();
	endtask

	// limit lowered under a partial word with a pending backslash: both lost
	task automatic test_limit_lowered_mid_line();
		write_limit(6'd63);
		send_char(8'h61);
		send_char(CH_SPACE);
		send_char(CH_DQUOTE);
		send_char(8'h62);
		send_char(CH_BSLASH);
		write_limit(6'd1);
		send_char(8'h63);
		send_eol();
	endtask

	// bytes past the word limit are ignored; a zero limit ignores every byte
	task automatic test_word_limit();
		write_limit(6'd2);
		send_char(8'h61);
		send_char(CH_SPACE);
		send_char(8'h62);
		send_char(CH_TAB);
		send_char(8'h63);
		send_char(CH_DQUOTE);
		send_eol();
		write_limit(6'd0);
		send_char(8'h61);
		send_char(CH_SPACE);
		send_eol();
	endtask

	// receiver stalls long enough for the core to fill and hold off input
	task automatic test_backpressure();
		bit saved_idle;
		saved_idle = tx_idle_en;
		write_limit(6'd63);
		tx_idle_en = 1'b0;
		long_hold_req = 60;
		repeat (30)
			send_char(($urandom_range(0, 3) == 0) ? CH_SPACE
				: 8'h61 + 8'($urandom_range(0, 25)));
		send_eol();
		tx_idle_en = saved_idle;
	endtask

	// mostly well-formed lines with heavy use of quotes and escapes, some noise
	task automatic send_random_line();
		int len;
		int pick;
		len = $urandom_range(1, 24);
		repeat (len) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				send_char(8'h61 + 8'($urandom_range(0, 25)));
			else if (pick < 45)
				send_char(CH_SPACE);
			else if (pick < 48)
				send_char(CH_TAB);
			else if (pick < 50)
				send_char(CH_NL);
			else if (pick < 58)
				send_char(CH_SQUOTE);
			else if (pick < 68)
				send_char(CH_DQUOTE);
			else if (pick < 78)
				send_char(CH_BSLASH);
			else if (pick < 83)
				send_char(CH_DOLLAR);
			else
				send_char(8'($urandom_range(0, 255)));
		end
		// now and then a line runs on into the next one
		if ($urandom_range(0, 11) != 0)
			send_eol();
	endtask

	task automatic test_random_lines(logic [IDX_W-1:0] lim, int target);
		int start;
		write_limit(lim);
		start = sent_items;
		while (sent_items - start < target)
			send_random_line();
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		push             = 1'b0;
		item             = '0;
		max_tokens_we    = 1'b0;
		max_tokens_wdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_quoting();
		test_word_overflow();
		test_limit_lowered_mid_line();
		test_word_limit();
		test_backpressure();
		test_random_lines(6'd63, 25);
		test_random_lines(6'd2, 10);
		test_random_lines(6'd1, 8);
		test_random_lines(6'd0, 4);
		test_random_lines(6'd17, 10);
		// last stretch at full rate on both sides
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_lines(6'd63, 20);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
